/* src/lzeg_pkg.sv */
// Shared types and codes for the LZ Elias-gamma stream decompressor.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package lzeg_pkg;

   // input item kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_DRAIN   = 2'd1;
   localparam logic [1:0] KIND_RESTART = 2'd2;

   // fixed stream constants
   localparam logic [31:0] GAMMA_END  = 32'd256;
   localparam logic [7:0]  MASK_FIRST = 8'd128;

   typedef enum logic [2:0] {
      ST_NEED       = 3'd0,
      ST_PENDING    = 3'd1,
      ST_END        = 3'd2,
      ST_BAD_OFF    = 3'd3,
      ST_AFTER_END  = 3'd4,
      ST_OVERFLOW   = 3'd5,
      ST_UNEXPECTED = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      PH_LIT_LEN    = 4'd0,
      PH_LIT_DATA   = 4'd1,
      PH_AFTER_LIT  = 4'd2,
      PH_REP_LEN    = 4'd3,
      PH_COPY       = 4'd4,
      PH_AFTER_COPY = 4'd5,
      PH_NEW_OFF    = 4'd6,
      PH_OFF_LOW    = 4'd7,
      PH_NEW_LEN    = 4'd8,
      PH_END        = 4'd9,
      PH_ERR_OFF    = 4'd10,
      PH_ERR_OVF    = 4'd11
   } phase_type;

   typedef enum logic [2:0] {
      C_IDLE  = 3'd0,
      C_START = 3'd1,
      C_STEP  = 3'd2,
      C_COPY  = 3'd3,
      C_READ  = 3'd4,
      C_SHOW  = 3'd5
   } ctrl_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // input transfer: latch payload, clear counts
      logic start;    // dispatch the item
      logic step;     // one decode step
      logic copy_wr;  // write back the byte read for a copy
      logic rd;       // read result buffer entry
      logic adv;      // result transfer done, next entry
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic done;     // item decode finished, status latched
      logic copy;     // step issued a history read
      logic last;     // current result is the final one
   } stat_type;

endpackage

/* src/lzeg_ctrl.sv */
// Controller state machine: sequences dispatch, decode steps, copy
// write-back and result delivery. Depends on lzeg_pkg.
`timescale 1ns / 1ps
module lzeg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lzeg_pkg::stat_type  stat,
   output lzeg_pkg::cmd_type   cmd
);

   lzeg_pkg::ctrl_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzeg_pkg::C_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzeg_pkg::C_IDLE: begin
            if (req_valid) state_in = lzeg_pkg::C_START;
         end
         lzeg_pkg::C_START, lzeg_pkg::C_STEP: begin
            if (stat.done)      state_in = lzeg_pkg::C_READ;
            else if (stat.copy) state_in = lzeg_pkg::C_COPY;
            else                state_in = lzeg_pkg::C_STEP;
         end
         lzeg_pkg::C_COPY: state_in = lzeg_pkg::C_STEP;
         lzeg_pkg::C_READ: state_in = lzeg_pkg::C_SHOW;
         lzeg_pkg::C_SHOW: begin
            if (rsp_ready) state_in = stat.last ? lzeg_pkg::C_IDLE : lzeg_pkg::C_READ;
         end
         default: state_in = lzeg_pkg::C_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         lzeg_pkg::C_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         lzeg_pkg::C_START: cmd.start   = 1'b1;
         lzeg_pkg::C_STEP:  cmd.step    = 1'b1;
         lzeg_pkg::C_COPY:  cmd.copy_wr = 1'b1;
         lzeg_pkg::C_READ:  cmd.rd      = 1'b1;
         lzeg_pkg::C_SHOW: begin
            rsp_valid = 1'b1;
            cmd.adv   = rsp_ready;
         end
         default: cmd = '0;
      endcase
   end

   // a dispatch or step never asks for a copy and finishes at once
   a_done_copy_excl: assert property (@(posedge clock) disable iff (reset)
      (cmd.start || cmd.step) |-> !(stat.done && stat.copy))
      else $error("done and copy together");
   // copy write-back always follows a decode step
   a_copy_after_step: assert property (@(posedge clock) disable iff (reset)
      cmd.copy_wr |-> $past(cmd.step || cmd.start))
      else $error("copy write-back without read");
   // no input is taken while results are shown
   a_no_accept_show: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken during result delivery");

endmodule

/* src/lzeg_datapath.sv */
// Datapath: decoder state, history window memory, result buffer memory
// and the per-step decode logic. Depends on lzeg_pkg.
`timescale 1ns / 1ps
module lzeg_datapath #(
   parameter int WINDOW_SIZE = 32768,
   parameter int MAX_BURST   = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  lzeg_pkg::cmd_type  cmd,
   output lzeg_pkg::stat_type stat,
   input  logic [1:0]         req_kind,
   input  logic [7:0]         req_in_byte,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_byte_valid,
   output logic               rsp_last,
   output logic [2:0]         rsp_status
);

   localparam int WP_W  = $clog2(WINDOW_SIZE);
   localparam int BW_W  = $clog2(WINDOW_SIZE + 1);
   localparam int SW    = BW_W + 1;
   localparam int N_W   = $clog2(MAX_BURST + 1);
   localparam int IDX_W = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
   localparam logic [SW-1:0]   WIN_S  = SW'(WINDOW_SIZE);
   localparam logic [BW_W-1:0] WIN_B  = BW_W'(WINDOW_SIZE);
   localparam logic [N_W-1:0]  MAX_N  = N_W'(MAX_BURST);

   // payload of the current item
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;

   // decoder state
   lzeg_pkg::phase_type phase_ff, phase_in;
   logic [WP_W-1:0] wp_ff, wp_in;
   logic [BW_W-1:0] bw_ff, bw_in, prev_ff, prev_in;
   logic [7:0]  bbyte_ff, bbyte_in, mask_ff, mask_in, recent_ff, recent_in;
   logic        reuse_ff, reuse_in, expect_ff, expect_in, have_ff, have_in;
   logic [31:0] acc_ff, acc_in, cr_ff, cr_in;
   logic [N_W-1:0] n_ff, n_in, k_ff;
   lzeg_pkg::status_type st_ff, st_in;

   // memories
   logic [7:0] hist_mem [WINDOW_SIZE];
   logic [7:0] obuf_mem [MAX_BURST];
   logic [7:0] hist_rd_ff, obuf_rd_ff;

   // step results
   logic            hist_we, obuf_we, hist_re, done;
   logic [7:0]      wdata;
   logic [WP_W-1:0] src;

   // fetch-bit helper signals
   logic       fb_need, fb_bit;
   logic [7:0] fb_mask_sh;
   logic [31:0] g;
   logic [39:0] off;
   logic [SW-1:0] wp_s, src_s;
   logic [WP_W:0] wp_inc;

   // copy source address
   always_comb begin
      wp_s = SW'(wp_ff);
      if (wp_s >= SW'(prev_ff)) src_s = wp_s - SW'(prev_ff);
      else                      src_s = wp_s + WIN_S - SW'(prev_ff);
      if (src_s >= WIN_S) src_s = '0;
      src = src_s[WP_W-1:0];
   end

   assign fb_need    = !reuse_ff && (mask_ff[7:1] == 7'd0) && !have_ff;
   assign fb_mask_sh = mask_ff >> 1;
   assign g          = acc_ff;
   assign off        = {1'b0, cr_ff, 7'd0} - {33'd0, byte_ff[7:1]};
   assign wp_inc     = {1'b0, wp_ff} + 1'b1;

   // one decode step, dispatch and copy write-back
   always_comb begin
      phase_in  = phase_ff;
      wp_in     = wp_ff;
      bw_in     = bw_ff;
      prev_in   = prev_ff;
      bbyte_in  = bbyte_ff;
      mask_in   = mask_ff;
      recent_in = recent_ff;
      reuse_in  = reuse_ff;
      expect_in = expect_ff;
      have_in   = have_ff;
      acc_in    = acc_ff;
      cr_in     = cr_ff;
      n_in      = n_ff;
      st_in     = st_ff;
      done      = 1'b0;
      hist_we   = 1'b0;
      obuf_we   = 1'b0;
      hist_re   = 1'b0;
      wdata     = byte_ff;
      fb_bit    = 1'b0;

      if (cmd.load) begin
         n_in = '0;
      end else if (cmd.start) begin
         // item dispatch
         done = 1'b1;
         if (kind_ff == lzeg_pkg::KIND_RESTART) begin
            phase_in  = lzeg_pkg::PH_LIT_LEN;
            wp_in     = '0;
            bw_in     = '0;
            prev_in   = BW_W'(1);
            bbyte_in  = '0;
            mask_in   = '0;
            recent_in = '0;
            reuse_in  = 1'b0;
            expect_in = 1'b0;
            acc_in    = 32'd1;
            cr_in     = '0;
            st_in     = lzeg_pkg::ST_NEED;
         end else if (kind_ff != lzeg_pkg::KIND_BYTE && kind_ff != lzeg_pkg::KIND_DRAIN) begin
            st_in = lzeg_pkg::ST_UNEXPECTED;
         end else if (phase_ff == lzeg_pkg::PH_ERR_OFF) begin
            st_in = lzeg_pkg::ST_BAD_OFF;
         end else if (phase_ff == lzeg_pkg::PH_ERR_OVF) begin
            st_in = lzeg_pkg::ST_OVERFLOW;
         end else if (kind_ff == lzeg_pkg::KIND_BYTE) begin
            if (phase_ff == lzeg_pkg::PH_END) st_in = lzeg_pkg::ST_AFTER_END;
            else if (phase_ff == lzeg_pkg::PH_COPY) st_in = lzeg_pkg::ST_UNEXPECTED;
            else begin
               done    = 1'b0;
               have_in = 1'b1;
            end
         end else begin
            if (phase_ff == lzeg_pkg::PH_COPY) begin
               done    = 1'b0;
               have_in = 1'b0;
            end else st_in = lzeg_pkg::ST_UNEXPECTED;
         end
      end else if (cmd.copy_wr) begin
         // emit the byte read from the window
         wdata   = hist_rd_ff;
         hist_we = 1'b1;
         obuf_we = 1'b1;
         wp_in   = (wp_inc == (WP_W + 1)'(WINDOW_SIZE)) ? '0 : wp_inc[WP_W-1:0];
         if (bw_ff < WIN_B) bw_in = bw_ff + 1'b1;
         n_in    = n_ff + 1'b1;
         cr_in   = cr_ff - 32'd1;
      end else if (cmd.step) begin
         case (phase_ff)
            lzeg_pkg::PH_LIT_LEN, lzeg_pkg::PH_REP_LEN, lzeg_pkg::PH_NEW_OFF,
            lzeg_pkg::PH_NEW_LEN, lzeg_pkg::PH_AFTER_LIT, lzeg_pkg::PH_AFTER_COPY: begin
               if (fb_need) begin
                  done  = 1'b1;
                  st_in = lzeg_pkg::ST_NEED;
               end else begin
                  // bit fetch: reused low bit, next bit, or a fresh bit byte
                  if (reuse_ff) begin
                     reuse_in = 1'b0;
                     fb_bit   = recent_ff[0];
                  end else if (mask_ff[7:1] != 7'd0) begin
                     mask_in = fb_mask_sh;
                     fb_bit  = |(bbyte_ff & fb_mask_sh);
                  end else begin
                     have_in   = 1'b0;
                     bbyte_in  = byte_ff;
                     recent_in = byte_ff;
                     mask_in   = lzeg_pkg::MASK_FIRST;
                     fb_bit    = byte_ff[7];
                  end
                  if (phase_ff == lzeg_pkg::PH_AFTER_LIT ||
                      phase_ff == lzeg_pkg::PH_AFTER_COPY) begin
                     if (fb_bit) phase_in = lzeg_pkg::PH_NEW_OFF;
                     else if (phase_ff == lzeg_pkg::PH_AFTER_LIT)
                        phase_in = lzeg_pkg::PH_REP_LEN;
                     else phase_in = lzeg_pkg::PH_LIT_LEN;
                  end else if (expect_ff) begin
                     if (acc_ff[31]) begin
                        phase_in = lzeg_pkg::PH_ERR_OVF;
                        done     = 1'b1;
                        st_in    = lzeg_pkg::ST_OVERFLOW;
                     end else begin
                        acc_in    = {acc_ff[30:0], fb_bit};
                        expect_in = 1'b0;
                     end
                  end else if (!fb_bit) begin
                     expect_in = 1'b1;
                  end else begin
                     // gamma value complete
                     acc_in    = 32'd1;
                     expect_in = 1'b0;
                     if (phase_ff == lzeg_pkg::PH_LIT_LEN) begin
                        cr_in    = g;
                        phase_in = lzeg_pkg::PH_LIT_DATA;
                     end else if (phase_ff == lzeg_pkg::PH_REP_LEN) begin
                        if (prev_ff > bw_ff) begin
                           phase_in = lzeg_pkg::PH_ERR_OFF;
                           done     = 1'b1;
                           st_in    = lzeg_pkg::ST_BAD_OFF;
                        end else begin
                           cr_in    = g;
                           phase_in = lzeg_pkg::PH_COPY;
                        end
                     end else if (phase_ff == lzeg_pkg::PH_NEW_OFF) begin
                        if (g == lzeg_pkg::GAMMA_END) begin
                           phase_in = lzeg_pkg::PH_END;
                           done     = 1'b1;
                           st_in    = lzeg_pkg::ST_END;
                        end else begin
                           cr_in    = g;
                           phase_in = lzeg_pkg::PH_OFF_LOW;
                        end
                     end else begin
                        if (g == 32'hFFFF_FFFF) begin
                           phase_in = lzeg_pkg::PH_ERR_OVF;
                           done     = 1'b1;
                           st_in    = lzeg_pkg::ST_OVERFLOW;
                        end else begin
                           cr_in    = g + 32'd1;
                           phase_in = lzeg_pkg::PH_COPY;
                        end
                     end
                  end
               end
            end
            lzeg_pkg::PH_LIT_DATA: begin
               if (!have_ff || n_ff >= MAX_N) begin
                  done  = 1'b1;
                  st_in = lzeg_pkg::ST_NEED;
               end else begin
                  have_in   = 1'b0;
                  recent_in = byte_ff;
                  hist_we   = 1'b1;
                  obuf_we   = 1'b1;
                  wp_in     = (wp_inc == (WP_W + 1)'(WINDOW_SIZE)) ? '0 : wp_inc[WP_W-1:0];
                  if (bw_ff < WIN_B) bw_in = bw_ff + 1'b1;
                  n_in      = n_ff + 1'b1;
                  cr_in     = cr_ff - 32'd1;
                  if (cr_ff == 32'd1) phase_in = lzeg_pkg::PH_AFTER_LIT;
               end
            end
            lzeg_pkg::PH_OFF_LOW: begin
               if (!have_ff) begin
                  done  = 1'b1;
                  st_in = lzeg_pkg::ST_NEED;
               end else begin
                  have_in   = 1'b0;
                  recent_in = byte_ff;
                  if (off > {{(40 - BW_W){1'b0}}, bw_ff}) begin
                     phase_in = lzeg_pkg::PH_ERR_OFF;
                     done     = 1'b1;
                     st_in    = lzeg_pkg::ST_BAD_OFF;
                  end else begin
                     prev_in  = off[BW_W-1:0];
                     cr_in    = '0;
                     reuse_in = 1'b1;
                     phase_in = lzeg_pkg::PH_NEW_LEN;
                  end
               end
            end
            lzeg_pkg::PH_COPY: begin
               if (cr_ff == 32'd0) begin
                  phase_in = lzeg_pkg::PH_AFTER_COPY;
               end else if (n_ff >= MAX_N) begin
                  done  = 1'b1;
                  st_in = lzeg_pkg::ST_PENDING;
               end else begin
                  hist_re = 1'b1;
               end
            end
            lzeg_pkg::PH_END: begin
               done  = 1'b1;
               st_in = lzeg_pkg::ST_END;
            end
            lzeg_pkg::PH_ERR_OFF: begin
               done  = 1'b1;
               st_in = lzeg_pkg::ST_BAD_OFF;
            end
            default: begin
               phase_in = lzeg_pkg::PH_ERR_OVF;
               done     = 1'b1;
               st_in    = lzeg_pkg::ST_OVERFLOW;
            end
         endcase
      end
   end

   assign stat.done = done;
   assign stat.copy = hist_re;
   assign stat.last = (n_ff == '0) || ((k_ff + 1'b1) == n_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lzeg_pkg::PH_LIT_LEN;
         wp_ff     <= '0;
         bw_ff     <= '0;
         prev_ff   <= BW_W'(1);
         bbyte_ff  <= '0;
         mask_ff   <= '0;
         recent_ff <= '0;
         reuse_ff  <= 1'b0;
         expect_ff <= 1'b0;
         have_ff   <= 1'b0;
         acc_ff    <= 32'd1;
         cr_ff     <= '0;
         n_ff      <= '0;
         k_ff      <= '0;
         st_ff     <= lzeg_pkg::ST_NEED;
      end else begin
         phase_ff  <= phase_in;
         wp_ff     <= wp_in;
         bw_ff     <= bw_in;
         prev_ff   <= prev_in;
         bbyte_ff  <= bbyte_in;
         mask_ff   <= mask_in;
         recent_ff <= recent_in;
         reuse_ff  <= reuse_in;
         expect_ff <= expect_in;
         have_ff   <= have_in;
         acc_ff    <= acc_in;
         cr_ff     <= cr_in;
         n_ff      <= n_in;
         st_ff     <= st_in;
         if (cmd.load)     k_ff <= '0;
         else if (cmd.adv) k_ff <= k_ff + 1'b1;
      end
   end

   // item payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_kind;
         byte_ff <= req_in_byte;
      end
   end

   // history window
   always_ff @(posedge clock) begin
      if (hist_we) hist_mem[wp_ff] <= wdata;
      if (hist_re) hist_rd_ff <= hist_mem[src];
   end

   // result buffer
   always_ff @(posedge clock) begin
      if (obuf_we) obuf_mem[n_ff[IDX_W-1:0]] <= wdata;
      if (cmd.rd)  obuf_rd_ff <= obuf_mem[k_ff[IDX_W-1:0]];
   end

   assign rsp_byte_valid = (n_ff != '0);
   assign rsp_out_byte   = rsp_byte_valid ? obuf_rd_ff : 8'd0;
   assign rsp_last       = stat.last;
   assign rsp_status     = st_ff;

   a_n_bound: assert property (@(posedge clock) disable iff (reset) n_ff <= MAX_N)
      else $error("result count beyond burst");
   a_bw_bound: assert property (@(posedge clock) disable iff (reset) bw_ff <= WIN_B)
      else $error("written count beyond window");
   a_wp_bound: assert property (@(posedge clock) disable iff (reset)
      (WP_W + 1)'(wp_ff) < (WP_W + 1)'(WINDOW_SIZE))
      else $error("write pointer beyond window");
   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> (k_ff < n_ff || n_ff == '0))
      else $error("result read beyond count");

endmodule

/* src/lz_elias_gamma_stream_decompressor_unit.sv */
// Channel  Handshake            Fields                                            Dir
// req      req_valid/req_ready  req_kind req_in_byte                              in
// rsp      rsp_valid/rsp_ready  rsp_out_byte rsp_byte_valid rsp_last rsp_status  out
// One item at a time: load and dispatch, then the decode steps, each copied
// byte as a history memory read step followed by its write-back, then each
// result read from the result buffer and held until rsp_ready takes it.
// Reset is synchronous and clears all decoder state; the window is not cleared.
// A stalled rsp_ready holds the current result and blocks new input.
// Top level: instantiates lzeg_ctrl and lzeg_datapath; depends on lzeg_pkg.
`timescale 1ns / 1ps
module lz_elias_gamma_stream_decompressor_unit #(
   parameter int WINDOW_SIZE = 32768,
   parameter int MAX_BURST   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic [2:0] rsp_status
);

   lzeg_pkg::cmd_type  cmd;
   lzeg_pkg::stat_type stat;

   lzeg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lzeg_datapath #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .MAX_BURST   (MAX_BURST)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_kind),
      .req_in_byte    (req_in_byte),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status)
   );

endmodule

/* sim/lzeg_stream_checker.sv */
// Result checker for the LZ Elias-gamma stream decompressor: watches both channels,
// predicts every result of each accepted request and compares them in order.
// Depends on lzeg_pkg for status and phase codes.
`timescale 1ns / 1ps
module lzeg_stream_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_byte_valid,
   input  logic       rsp_last,
   input  logic [2:0] rsp_status,
   output int         fail_count,
   output int         due_count
);

   localparam int WIN   = 32768;
   localparam int BURST = 64;

   typedef struct packed {
      logic [7:0]           data;
      logic                 data_ok;
      logic                 last;
      lzeg_pkg::status_type status;
   } result_rec_type;

   result_rec_type due_results[$];   // predicted, not yet seen on rsp
   result_rec_type item_results[$];  // results of the request being decoded

   // decoder copy
   logic [7:0]  hist [0:WIN-1];
   int unsigned wr_ptr;
   int unsigned filled;
   int unsigned prev_off;
   logic [31:0] acc;
   logic [31:0] remaining;
   lzeg_pkg::phase_type phase;
   logic [7:0]  bit_reg;
   logic [7:0]  mask;
   logic [7:0]  last_data;
   logic [7:0]  in_val;
   logic        reuse_bit;
   logic        want_val;
   logic        byte_avail;

   task automatic clear_decoder();
      for (int i = 0; i < WIN; i++) hist[i] = 8'h00;
      wr_ptr = 0;
      filled = 0;
      prev_off = 1;
      phase = lzeg_pkg::PH_LIT_LEN;
      bit_reg = 8'h00;
      mask = 8'h00;
      reuse_bit = 1'b0;
      last_data = 8'h00;
      acc = 32'd1;
      want_val = 1'b0;
      remaining = 32'd0;
   endtask

   // window write plus one result
   task automatic put_out(input logic [7:0] v);
      result_rec_type r;
      hist[wr_ptr] = v;
      wr_ptr = (wr_ptr + 1 >= WIN) ? 0 : wr_ptr + 1;
      if (filled < WIN) filled++;
      r.data = v;
      r.data_ok = 1'b1;
      r.last = 1'b0;
      r.status = lzeg_pkg::ST_NEED;
      item_results.push_back(r);
   endtask

   // next flag/gamma bit: reused low bit, rest of bit byte, or a fresh bit byte
   function automatic int next_bit();
      if (reuse_bit) begin
         reuse_bit = 1'b0;
         return int'(last_data[0]);
      end
      if (mask > 8'd1) begin
         mask = mask >> 1;
         return ((bit_reg & mask) != 0) ? 1 : 0;
      end
      if (!byte_avail) return -1;
      byte_avail = 1'b0;
      bit_reg = in_val;
      last_data = in_val;
      mask = lzeg_pkg::MASK_FIRST;
      return int'(in_val[7]);
   endfunction

   // runs the decoder until it needs input or stops
   task automatic run_decoder(output lzeg_pkg::status_type st);
      int          b;
      logic [31:0] g;
      logic [63:0] off;
      int unsigned src;
      bit          fin;
      fin = 1'b0;
      while (!fin) begin
         case (phase)
            lzeg_pkg::PH_LIT_LEN, lzeg_pkg::PH_REP_LEN, lzeg_pkg::PH_NEW_OFF,
            lzeg_pkg::PH_NEW_LEN: begin
               b = next_bit();
               if (b < 0) begin
                  st = lzeg_pkg::ST_NEED;
                  fin = 1'b1;
               end else if (want_val) begin
                  if (acc[31]) begin
                     phase = lzeg_pkg::PH_ERR_OVF;
                     st = lzeg_pkg::ST_OVERFLOW;
                     fin = 1'b1;
                  end else begin
                     acc = {acc[30:0], b[0]};
                     want_val = 1'b0;
                  end
               end else if (b == 0) begin
                  want_val = 1'b1;
               end else begin
                  g = acc;
                  acc = 32'd1;
                  want_val = 1'b0;
                  if (phase == lzeg_pkg::PH_LIT_LEN) begin
                     remaining = g;
                     phase = lzeg_pkg::PH_LIT_DATA;
                  end else if (phase == lzeg_pkg::PH_REP_LEN) begin
                     if (prev_off > filled) begin
                        phase = lzeg_pkg::PH_ERR_OFF;
                        st = lzeg_pkg::ST_BAD_OFF;
                        fin = 1'b1;
                     end else begin
                        remaining = g;
                        phase = lzeg_pkg::PH_COPY;
                     end
                  end else if (phase == lzeg_pkg::PH_NEW_OFF) begin
                     if (g == lzeg_pkg::GAMMA_END) begin
                        phase = lzeg_pkg::PH_END;
                        st = lzeg_pkg::ST_END;
                        fin = 1'b1;
                     end else begin
                        remaining = g;
                        phase = lzeg_pkg::PH_OFF_LOW;
                     end
                  end else begin
                     if (g == 32'hFFFF_FFFF) begin
                        phase = lzeg_pkg::PH_ERR_OVF;
                        st = lzeg_pkg::ST_OVERFLOW;
                        fin = 1'b1;
                     end else begin
                        remaining = g + 32'd1;
                        phase = lzeg_pkg::PH_COPY;
                     end
                  end
               end
            end
            lzeg_pkg::PH_LIT_DATA: begin
               if (!byte_avail || item_results.size() >= BURST) begin
                  st = lzeg_pkg::ST_NEED;
                  fin = 1'b1;
               end else begin
                  byte_avail = 1'b0;
                  last_data = in_val;
                  put_out(in_val);
                  remaining = remaining - 32'd1;
                  if (remaining == 32'd0) phase = lzeg_pkg::PH_AFTER_LIT;
               end
            end
            lzeg_pkg::PH_AFTER_LIT, lzeg_pkg::PH_AFTER_COPY: begin
               b = next_bit();
               if (b < 0) begin
                  st = lzeg_pkg::ST_NEED;
                  fin = 1'b1;
               end else if (b != 0) begin
                  phase = lzeg_pkg::PH_NEW_OFF;
               end else begin
                  phase = (phase == lzeg_pkg::PH_AFTER_LIT) ? lzeg_pkg::PH_REP_LEN
                                                            : lzeg_pkg::PH_LIT_LEN;
               end
            end
            lzeg_pkg::PH_OFF_LOW: begin
               if (!byte_avail) begin
                  st = lzeg_pkg::ST_NEED;
                  fin = 1'b1;
               end else begin
                  byte_avail = 1'b0;
                  last_data = in_val;
                  off = {25'd0, remaining, 7'd0} - {57'd0, in_val[7:1]};
                  if (off > 64'(filled)) begin
                     phase = lzeg_pkg::PH_ERR_OFF;
                     st = lzeg_pkg::ST_BAD_OFF;
                     fin = 1'b1;
                  end else begin
                     prev_off = off[31:0];
                     remaining = 32'd0;
                     reuse_bit = 1'b1;
                     phase = lzeg_pkg::PH_NEW_LEN;
                  end
               end
            end
            lzeg_pkg::PH_COPY: begin
               if (remaining == 32'd0) begin
                  phase = lzeg_pkg::PH_AFTER_COPY;
               end else if (item_results.size() >= BURST) begin
                  st = lzeg_pkg::ST_PENDING;
                  fin = 1'b1;
               end else begin
                  src = (wr_ptr >= prev_off) ? wr_ptr - prev_off : wr_ptr + WIN - prev_off;
                  if (src >= WIN) src = 0;
                  put_out(hist[src]);
                  remaining = remaining - 32'd1;
               end
            end
            lzeg_pkg::PH_END: begin
               st = lzeg_pkg::ST_END;
               fin = 1'b1;
            end
            lzeg_pkg::PH_ERR_OFF: begin
               st = lzeg_pkg::ST_BAD_OFF;
               fin = 1'b1;
            end
            default: begin
               phase = lzeg_pkg::PH_ERR_OVF;
               st = lzeg_pkg::ST_OVERFLOW;
               fin = 1'b1;
            end
         endcase
      end
   endtask

   // predicts all results of one request transfer
   task automatic decode_item(input logic [1:0] kind, input logic [7:0] data);
      lzeg_pkg::status_type st;
      result_rec_type       r;
      item_results.delete();
      if (kind == lzeg_pkg::KIND_RESTART) begin
         clear_decoder();
         st = lzeg_pkg::ST_NEED;
      end else if (kind != lzeg_pkg::KIND_BYTE && kind != lzeg_pkg::KIND_DRAIN) begin
         st = lzeg_pkg::ST_UNEXPECTED;
      end else if (phase == lzeg_pkg::PH_ERR_OFF) begin
         st = lzeg_pkg::ST_BAD_OFF;
      end else if (phase == lzeg_pkg::PH_ERR_OVF) begin
         st = lzeg_pkg::ST_OVERFLOW;
      end else if (kind == lzeg_pkg::KIND_BYTE) begin
         if (phase == lzeg_pkg::PH_END) st = lzeg_pkg::ST_AFTER_END;
         else if (phase == lzeg_pkg::PH_COPY) st = lzeg_pkg::ST_UNEXPECTED;
         else begin
            in_val = data;
            byte_avail = 1'b1;
            run_decoder(st);
         end
      end else begin
         if (phase == lzeg_pkg::PH_COPY) begin
            in_val = 8'h00;
            byte_avail = 1'b0;
            run_decoder(st);
         end else st = lzeg_pkg::ST_UNEXPECTED;
      end
      if (item_results.size() == 0) begin
         r = '0;
         item_results.push_back(r);
      end
      for (int k = 0; k < item_results.size(); k++) begin
         r = item_results[k];
         r.last = (k == item_results.size() - 1);
         r.status = st;
         due_results.push_back(r);
      end
   endtask

   initial begin
      fail_count = 0;
      due_count = 0;
   end

   // compare result transfers, then predict on request transfers
   always @(posedge clock) begin
      result_rec_type got;
      result_rec_type want;
      if (reset) begin
         clear_decoder();
         due_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = {rsp_out_byte, rsp_byte_valid, rsp_last,
                   lzeg_pkg::status_type'(rsp_status)};
            if (due_results.size() == 0) begin
               if (fail_count < 10)
                  $display("result with none expected: byte %02h ok %0b last %0b status %0d",
                           got.data, got.data_ok, got.last, got.status);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               if (got !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: exp %02h %0b %0b %0d, got %02h %0b %0b %0d",
                              want.data, want.data_ok, want.last, want.status,
                              got.data, got.data_ok, got.last, got.status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) decode_item(req_kind, req_in_byte);
      end
      due_count = due_results.size();
   end

endmodule

/* sim/lz_elias_gamma_stream_decompressor_unit_tb.sv */
// Top of the decompressor testbench: encodes LZ streams with interlaced gamma codes,
// drives them with random idling and gives the verdict.
// Depends on lzeg_pkg, the decompressor unit and lzeg_stream_checker.
`timescale 1ns / 1ps
module lz_elias_gamma_stream_decompressor_unit_tb;

   localparam logic [1:0] KIND_UNKNOWN = 2'd3;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int QUIET_ITEMS  = 20;
   localparam int TOTAL_ITEMS  = 100;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_kind;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_last;
   logic [2:0] rsp_status;
   int         fail_count;
   int         due_count;
   int         cycles;
   bit         quiet;

   // encoded stream under construction
   logic [7:0] bstream[$];
   int         drains[$];
   bit         lit_flag[$];
   int         bidx;
   logic [7:0] bmask;
   int         emitted;

   // request transfers to send
   logic [1:0] it_kind[$];
   logic [7:0] it_byte[$];
   int         hold_at;

   lz_elias_gamma_stream_decompressor_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_last(rsp_last), .rsp_status(rsp_status)
   );

   lzeg_stream_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_kind), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte), .rsp_byte_valid(rsp_byte_valid),
      .rsp_last(rsp_last), .rsp_status(rsp_status),
      .fail_count(fail_count), .due_count(due_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("[lz_elias_gamma_stream_decompressor_unit] ERROR");
         $finish;
      end
   end

   // ---------------- stream encoder ----------------
   task automatic begin_stream();
      bstream.delete();
      drains.delete();
      lit_flag.delete();
      bmask = 8'h00;
      emitted = 0;
   endtask

   task automatic push_byte(input logic [7:0] v, input bit is_lit);
      bstream.push_back(v);
      drains.push_back(0);
      lit_flag.push_back(is_lit);
   endtask

   // bits are packed MSB first into bit bytes placed where the decoder fetches them
   task automatic put_bit(input bit v);
      if (bmask == 8'h00) begin
         bidx = bstream.size();
         push_byte(8'h00, 1'b0);
         bmask = lzeg_pkg::MASK_FIRST;
      end
      if (v) bstream[bidx] = bstream[bidx] | bmask;
      bmask = bmask >> 1;
   endtask

   // interlaced gamma: (0, value bit) per bit below the top one, then 1
   task automatic put_gamma(input logic [31:0] v, input bit skip_first);
      int k;
      bit started;
      k = 31;
      while (k > 0 && !v[k]) k--;
      started = !skip_first;
      for (int i = k - 1; i >= 0; i--) begin
         if (started) put_bit(1'b0);
         started = 1'b1;
         put_bit(v[i]);
      end
      if (started) put_bit(1'b1);
   endtask

   // drains follow the transfer that starts the copy; a literal there already used one slot
   task automatic add_drains(input int len);
      int idx;
      idx = bstream.size() - 1;
      drains[idx] += (len + int'(lit_flag[idx]) - 1) / 64;
   endtask

   task automatic lit_run(input int len);
      put_gamma(len, 1'b0);
      repeat (len) push_byte(8'($urandom_range(0, 255)), 1'b1);
      emitted += len;
   endtask

   task automatic rep_copy(input int len);
      put_gamma(len, 1'b0);
      add_drains(len);
      emitted += len;
   endtask

   // new offset; copy length is gval + 1
   task automatic new_copy(input int off, input logic [31:0] gval);
      int hi;
      int lo;
      hi = (off + 127) / 128;
      lo = hi * 128 - off;
      put_gamma(hi, 1'b0);
      push_byte({lo[6:0], (gval > 1) ? 1'b0 : 1'b1}, 1'b0);
      put_gamma(gval, 1'b1);
      if (gval != 32'hFFFF_FFFF) begin
         add_drains(gval + 1);
         emitted += gval + 1;
      end
   endtask

   task automatic end_stream();
      put_bit(1'b1);
      put_gamma(lzeg_pkg::GAMMA_END, 1'b0);
   endtask

   task automatic add_item(input logic [1:0] k, input logic [7:0] v);
      it_kind.push_back(k);
      it_byte.push_back(v);
   endtask

   // turn the encoded stream into transfers, with optional stray items mixed in
   task automatic flush(input bit noisy);
      add_item(lzeg_pkg::KIND_RESTART, 8'($urandom_range(0, 255)));
      for (int i = 0; i < bstream.size(); i++) begin
         if (noisy && $urandom_range(0, 15) == 0)
            add_item(KIND_UNKNOWN, 8'($urandom_range(0, 255)));
         add_item(lzeg_pkg::KIND_BYTE, bstream[i]);
         if (noisy && drains[i] > 0 && $urandom_range(0, 2) == 0)
            add_item(lzeg_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
         repeat (drains[i]) add_item(lzeg_pkg::KIND_DRAIN, 8'($urandom_range(0, 255)));
         if (noisy && drains[i] == 0 && $urandom_range(0, 15) == 0)
            add_item(lzeg_pkg::KIND_DRAIN, 8'($urandom_range(0, 255)));
      end
      if (noisy && $urandom_range(0, 3) == 0)
         add_item(lzeg_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
   endtask

   function automatic int pick_len(input int lo);
      if ($urandom_range(0, 7) == 0) return $urandom_range(65, 180);
      return $urandom_range(lo, 8);
   endfunction

   task automatic random_stream();
      bit after_lit;
      begin_stream();
      lit_run($urandom_range(1, 5));
      after_lit = 1'b1;
      repeat ($urandom_range(2, 6)) begin
         if ($urandom_range(0, 1) == 1) begin
            put_bit(1'b0);
            if (after_lit) begin
               rep_copy(pick_len(1));
               after_lit = 1'b0;
            end else begin
               lit_run($urandom_range(1, 5));
               after_lit = 1'b1;
            end
         end else begin
            put_bit(1'b1);
            new_copy($urandom_range(1, emitted), pick_len(2) - 1);
            after_lit = 1'b0;
         end
      end
      end_stream();
      flush(1'b1);
   endtask

   task automatic build_items();
      // unknown kind and a drain with nothing pending, right after reset
      add_item(KIND_UNKNOWN, 8'hFF);
      add_item(lzeg_pkg::KIND_DRAIN, 8'h00);
      // literal extremes, repeat copy, short new copy, end, then a byte and a drain after end
      begin_stream();
      put_gamma(3, 1'b0);
      push_byte(8'h00, 1'b1);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h80, 1'b1);
      emitted = 3;
      put_bit(1'b0);
      rep_copy(2);
      put_bit(1'b1);
      new_copy(5, 1);
      end_stream();
      flush(1'b0);
      add_item(lzeg_pkg::KIND_BYTE, 8'h7F);
      add_item(lzeg_pkg::KIND_DRAIN, 8'h00);
      // gamma longer than 32 bits, sticky
      add_item(lzeg_pkg::KIND_RESTART, 8'h00);
      repeat (8) add_item(lzeg_pkg::KIND_BYTE, 8'h00);
      add_item(lzeg_pkg::KIND_BYTE, 8'h01);
      add_item(lzeg_pkg::KIND_DRAIN, 8'h00);
      // offset beyond written data, sticky
      begin_stream();
      lit_run(1);
      put_bit(1'b1);
      new_copy(9, 1);
      flush(1'b0);
      add_item(lzeg_pkg::KIND_BYTE, 8'h02);
      // new-offset copy length of 2^32
      begin_stream();
      lit_run(1);
      put_bit(1'b1);
      new_copy(1, 32'hFFFF_FFFF);
      flush(1'b0);
      // copy spanning several bursts, with a stray byte while pending
      begin_stream();
      lit_run(2);
      put_bit(1'b1);
      new_copy(2, 199);
      push_byte(8'h00, 1'b0);
      end_stream();
      add_item(lzeg_pkg::KIND_RESTART, 8'h00);
      for (int i = 0; i < bstream.size(); i++) begin
         add_item(lzeg_pkg::KIND_BYTE, bstream[i]);
         if (drains[i] > 0) add_item(lzeg_pkg::KIND_BYTE, 8'hAA);
         repeat (drains[i]) add_item(lzeg_pkg::KIND_DRAIN, 8'h00);
      end
      hold_at = it_kind.size();
      // random streams, some of them plain garbage
      while (it_kind.size() < TOTAL_ITEMS) begin
         if ($urandom_range(0, 7) == 0) begin
            add_item(lzeg_pkg::KIND_RESTART, 8'h00);
            repeat ($urandom_range(4, 10)) begin
               add_item(($urandom_range(0, 5) == 0) ? lzeg_pkg::KIND_DRAIN
                                                    : lzeg_pkg::KIND_BYTE,
                        8'($urandom_range(0, 255)));
            end
         end else random_stream();
      end
   endtask

   // ---------------- result side stalls ----------------
   initial begin
      int stall;
      stall = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 6) - 1;
            rsp_ready = 1'b0;
         end else rsp_ready = 1'b1;
      end
   end

   // ---------------- request side and verdict ----------------
   initial begin
      int total;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = lzeg_pkg::KIND_BYTE;
      req_in_byte = 8'h00;
      build_items();
      total = it_kind.size();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      for (int i = 0; i < total; i++) begin
         if (i == hold_at) begin
            while (due_count != 0) @(negedge clock);
         end
         if (i >= total - QUIET_ITEMS) quiet = 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clock);
         req_valid = 1'b1;
         req_kind = it_kind[i];
         req_in_byte = it_byte[i];
         do @(posedge clock); while (!req_ready);
         @(negedge clock);
         req_valid = 1'b0;
      end
      while (due_count != 0) @(negedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("[lz_elias_gamma_stream_decompressor_unit] OK");
      end else begin
         $display("[lz_elias_gamma_stream_decompressor_unit] ERROR");
      end
      $finish;
   end

endmodule
